/* design/iiel_pkg.sv */
// shared types and constants for the indexed insert/erase list
package iiel_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int KIND_W  = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // internal widths follow DEPTH
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } iiel_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  removed_word;
  } iiel_rsp_t;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_op_t;

  typedef struct packed {
    shift_op_t op;
    cmp_t      pos;
  } cell_ctl_t;

endpackage

/* design/iiel_cell.sv */
// one storage cell of the list: holds, loads, or takes a neighbor's word
module iiel_cell (
  input  logic              clk,
  input  iiel_pkg::cell_ctl_t ctl,
  input  iiel_pkg::idx_t    index,
  input  iiel_pkg::word_t   word_new,
  input  iiel_pkg::word_t   left_word,
  input  iiel_pkg::word_t   right_word,
  output iiel_pkg::word_t   word
);
  import iiel_pkg::*;

  cmp_t idx_ext;

  assign idx_ext = CMP_W'(index);

  always_ff @(posedge clk) begin
    case (ctl.op)
      SH_UP: begin
        if (idx_ext == ctl.pos) begin
          word <= word_new;
        end else if (idx_ext > ctl.pos) begin
          word <= left_word;
        end
      end
      SH_DOWN: begin
        if (idx_ext >= ctl.pos) begin
          word <= right_word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/indexed_insert_erase_list_unit.sv */
// top level of the indexed insert/erase list: control, cell row, result register
//
// Use: drive req and raise start for one cycle per request; a request is taken
// at a rising edge where start is high and busy is low. busy stays low, so a
// request may be given in every cycle.
// Each request gives exactly one result in the next cycle: done is high for that
// single cycle and rsp carries the new entry count, the status and, for erase,
// pop back and pop front, the removed word (zero otherwise).
// Throughput is one request per cycle: every cell of the
// row loads from its left or right neighbor, or the new word, in the same edge,
// and the removed word is picked from the row before that edge.
// A failing request (full, empty, position out of range) leaves the list as
// it was. Kinds 5 to 7 change nothing and report done with a zero word.
// Reset (rst, synchronous) empties the list and clears done; the cell words
// are not cleared, as entries at or above the count are never read.
// The receiver cannot stall: it must take each result in its done cycle.
module indexed_insert_erase_list_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  iiel_pkg::iiel_req_t req,
  output logic                done,
  output iiel_pkg::iiel_rsp_t rsp
);
  import iiel_pkg::*;

  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  count_next;
  logic [STAT_W-1:0] status_next;
  word_t             removed_next;
  cmp_t              fill_ext;
  cmp_t              eff_pos;
  cell_ctl_t         ctl;
  shift_op_t         op_sel;
  word_t             word_new;
  word_t             cell_word [DEPTH];
  logic              take;

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign fill_ext = CMP_W'(fill_count);
  assign word_new = DATA_WIDTH'(req.word_in);

  always_comb begin
    op_sel       = SH_HOLD;
    status_next  = ST_DONE;
    count_next   = fill_count;
    removed_next = '0;
    eff_pos      = CMP_W'(req.position);
    case (req.kind)
      KIND_INSERT, KIND_PUSH_FRONT: begin
        if (req.kind == KIND_PUSH_FRONT) begin
          eff_pos = '0;
        end
        if (fill_count == CNT_W'(DEPTH)) begin
          status_next = ST_FULL;
        end else if (eff_pos > fill_ext) begin
          status_next = ST_RANGE;
        end else begin
          op_sel     = SH_UP;
          count_next = fill_count + CNT_W'(1);
        end
      end
      KIND_ERASE, KIND_POP_BACK, KIND_POP_FRONT: begin
        if (fill_count == '0) begin
          status_next = ST_EMPTY;
        end else begin
          if (req.kind == KIND_POP_BACK) begin
            eff_pos = fill_ext - CMP_W'(1);
          end else if (req.kind == KIND_POP_FRONT) begin
            eff_pos = '0;
          end
          if (eff_pos >= fill_ext) begin
            status_next = ST_RANGE;
          end else begin
            op_sel       = SH_DOWN;
            removed_next = cell_word[eff_pos[IDX_W-1:0]];
            count_next   = fill_count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    ctl.op  = take ? op_sel : SH_HOLD;
    ctl.pos = eff_pos;
  end

  // row of cells, each fed by both neighbors; the ends see their own word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iiel_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .index      (IDX_W'(i)),
      .word_new   (word_new),
      .left_word  (cell_word[(i > 0) ? i - 1 : i]),
      .right_word (cell_word[(i < DEPTH - 1) ? i + 1 : i]),
      .word       (cell_word[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= take;
      if (take) begin
        fill_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.entry_count  <= COUNT_W'(count_next);
      rsp.status       <= status_next;
      rsp.removed_word <= WORD_W'(removed_next);
    end
  end

endmodule

/* design/iiel_checker.sv */
// port-level checks for the indexed insert/erase list, bound to the top level
module iiel_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input iiel_pkg::iiel_req_t req,
  input logic                done,
  input iiel_pkg::iiel_rsp_t rsp
);
  import iiel_pkg::*;

  // every taken request gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request not answered in the next cycle");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without a request");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.entry_count <= COUNT_W'(DEPTH)))
    else $error("entry count above capacity");

  // a failed request leaves the count as the previous result showed it
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && !$past(rst) && rsp.status != ST_DONE)
      |-> (rsp.entry_count == $past(rsp.entry_count)))
    else $error("failed request changed the count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0 && rsp.removed_word == '0))
    else $error("empty status with entries or a removed word");

endmodule

bind indexed_insert_erase_list_unit iiel_checker u_iiel_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .rsp   (rsp)
);
